### rtl/prc_pkg.sv
// Shared types, widths and constants of the polar remap coordinate generator.
// No dependencies; every other file imports this package.
`default_nettype none
package prc_pkg;
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int HALF_W    = 12;
  localparam int OUT_W     = 22;
  localparam int LG_W      = 20;
  localparam int SQ_W      = 29;
  localparam int ROOT_W    = 31;
  localparam int ROOT_N    = 16;
  localparam int LOG_STEPS = 16;
  localparam int ISQ_W     = 62;
  localparam int NUM_W     = 44;
  localparam int RHO_W     = 32;
  localparam int ANG_W     = 32;
  localparam int CORDIC_N  = 20;
  localparam int CX_W      = 34;
  localparam int Z_W       = 33;
  localparam int ATAN_W    = 30;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [ATAN_W-1:0] CORDIC_GAIN = 30'd652032874;
  localparam logic [RHO_W-1:0]  RHO_CAP     = 32'h8000_0000;
  localparam logic [ROOT_W-1:0] ONE_Q30     = 31'h4000_0000;

  typedef enum logic [1:0] {
    REG_LOG_MODE   = 2'd0,
    REG_IMAGE_ROWS = 2'd1,
    REG_IMAGE_COLS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_LOG,
    ST_ROOT
  } setup_state_t;

  typedef struct packed {
    logic                          log_mode;
    logic [DIM_W-1:0]              rows;
    logic [DIM_W-1:0]              cols;
    logic [HALF_W-1:0]             half_rows;
    logic [HALF_W-1:0]             half_cols;
    logic [LG_W-1:0]               lg;
    logic [SQ_W-1:0]               sq;
    logic [ROOT_N-1:0][ROOT_W-1:0] root;
  } prc_cfg_t;

  typedef struct packed {
    logic [RHO_W-1:0] rho;
    logic [ANG_W-1:0] ang;
  } prc_item_t;

  function automatic logic [ATAN_W-1:0] atan_turn(input int unsigned i);
    logic [ATAN_W-1:0] a;
    case (i)
      0:       a = 30'd536870912;
      1:       a = 30'd316933406;
      2:       a = 30'd167458907;
      3:       a = 30'd85004756;
      4:       a = 30'd42667331;
      5:       a = 30'd21354465;
      6:       a = 30'd10679838;
      7:       a = 30'd5340245;
      8:       a = 30'd2670163;
      9:       a = 30'd1335087;
      10:      a = 30'd667544;
      11:      a = 30'd333772;
      12:      a = 30'd166886;
      13:      a = 30'd83443;
      14:      a = 30'd41722;
      15:      a = 30'd20861;
      16:      a = 30'd10430;
      17:      a = 30'd5215;
      18:      a = 30'd2608;
      19:      a = 30'd1304;
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage
`default_nettype wire

### rtl/prc_if.sv
// Stream interfaces for pixel coordinate requests and source coordinate results.
// Depends on prc_pkg.
`default_nettype none
interface prc_in_if;
  import prc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] col_index;
  logic [COORD_W-1:0] row_index;
  modport source(output valid, col_index, row_index, input ready);
  modport sink(input valid, col_index, row_index, output ready);
endinterface

interface prc_out_if;
  import prc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] source_x;
  logic signed [OUT_W-1:0] source_y;
  modport source(output valid, source_x, source_y, input ready);
  modport sink(input valid, source_x, source_y, output ready);
endinterface
`default_nettype wire

### rtl/prc_cfg.sv
// Configuration registers with APB-style write/read and the setup sequencer that
// derives log2(rows), the linear radius scale and the root-of-two table. Uses prc_pkg.
`default_nettype none
module prc_cfg #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]   paddr,
  input  logic [prc_pkg::DATA_W-1:0]   pwdata,
  output logic [prc_pkg::DATA_W-1:0]   prdata,
  output prc_pkg::prc_cfg_t            cfg,
  output logic                         busy
);
  import prc_pkg::*;

  localparam logic [ISQ_W-1:0] BIT_INIT  = ISQ_W'(1) << 60;
  localparam logic [ISQ_W-1:0] ROOT0_OP  = ISQ_W'(1) << 61;

  logic                          wr_en;
  reg_idx_t                      idx;
  logic                          log_mode_r;
  logic [DIM_W-1:0]              rows_r, cols_r;
  logic [DIM_W-1:0]              rows_c, cols_c;
  setup_state_t                  state_r, state_nxt;
  logic [ROOT_W-1:0]             m_r, m_nxt, m_init;
  logic [LG_W-1:0]               l_r, l_nxt;
  logic [3:0]                    cnt_r, cnt_nxt, msb;
  logic [ISQ_W-1:0]              rad_r, rad_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [ISQ_W-1:0]              trial, res_step;
  logic [4:0]                    ridx_r, ridx_nxt;
  logic [ROOT_N-1:0][ROOT_W-1:0] root_r, root_nxt;
  logic [SQ_W-1:0]               sq_r, sq_nxt;
  logic [2*ROOT_W-1:0]           sqr;
  logic [ROOT_W:0]               sqr_hi;
  logic [ISQ_W-1:0]              s_op;
  logic [2*HALF_W:0]             hyp;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W:0] lim;
    lim = (DIM_W+1)'(MAX_DIM);
    if (d == '0) return DIM_W'(1);
    if ({1'b0, d} > lim) return lim[DIM_W-1:0];
    return d;
  endfunction

  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign rows_c = clamp_dim(rows_r);
  assign cols_c = clamp_dim(cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_mode_r <= 1'b0;
      rows_r     <= 13'd512;
      cols_r     <= 13'd512;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOG_MODE:   log_mode_r <= pwdata[0];
        REG_IMAGE_ROWS: rows_r     <= pwdata[DIM_W-1:0];
        REG_IMAGE_COLS: cols_r     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOG_MODE:   prdata = {{(DATA_W-1){1'b0}}, log_mode_r};
      REG_IMAGE_ROWS: prdata = {{(DATA_W-DIM_W){1'b0}}, rows_r};
      REG_IMAGE_COLS: prdata = {{(DATA_W-DIM_W){1'b0}}, cols_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    msb = '0;
    for (int k = 0; k < DIM_W; k++) begin
      if (rows_c[k]) msb = 4'(k);
    end
  end

  assign m_init = {{(ROOT_W-DIM_W){1'b0}}, rows_c} << (5'd30 - {1'b0, msb});
  assign sqr    = (2*ROOT_W)'(m_r) * (2*ROOT_W)'(m_r);
  assign sqr_hi = sqr[2*ROOT_W-1:30];
  assign hyp    = (2*HALF_W+1)'(rows_c[DIM_W-1:1]) * (2*HALF_W+1)'(rows_c[DIM_W-1:1])
                + (2*HALF_W+1)'(cols_c[DIM_W-1:1]) * (2*HALF_W+1)'(cols_c[DIM_W-1:1]);
  assign s_op   = {{(ISQ_W-2*HALF_W-1-32){1'b0}}, hyp, 32'd0};
  assign trial  = res_r + bit_r;

  always_comb begin
    if (rad_r >= trial) begin
      res_step = (res_r >> 1) + bit_r;
    end else begin
      res_step = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    l_r    <= l_nxt;
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    ridx_r <= ridx_nxt;
    root_r <= root_nxt;
    sq_r   <= sq_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    l_nxt     = l_r;
    cnt_nxt   = cnt_r;
    rad_nxt   = rad_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    ridx_nxt  = ridx_r;
    root_nxt  = root_r;
    sq_nxt    = sq_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_START: begin
        m_nxt     = m_init;
        l_nxt     = LG_W'(msb);
        cnt_nxt   = '0;
        state_nxt = ST_LOG;
      end
      ST_LOG: begin
        if (sqr_hi[ROOT_W]) begin
          m_nxt = sqr_hi[ROOT_W:1];
          l_nxt = {l_r[LG_W-2:0], 1'b1};
        end else begin
          m_nxt = sqr_hi[ROOT_W-1:0];
          l_nxt = {l_r[LG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(LOG_STEPS-1)) begin
          rad_nxt   = ROOT0_OP;
          res_nxt   = '0;
          bit_nxt   = BIT_INIT;
          ridx_nxt  = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rad_r >= trial) rad_nxt = rad_r - trial;
        res_nxt = res_step;
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          res_nxt = '0;
          bit_nxt = BIT_INIT;
          if (ridx_r == 5'(ROOT_N)) begin
            sq_nxt    = res_step[SQ_W-1:0];
            state_nxt = ST_IDLE;
          end else begin
            root_nxt[ridx_r[3:0]] = res_step[ROOT_W-1:0];
            ridx_nxt              = ridx_r + 5'd1;
            if (ridx_r == 5'(ROOT_N-1)) begin
              rad_nxt = s_op;
            end else begin
              rad_nxt = {1'b0, res_step[ROOT_W-1:0], 30'd0};
            end
          end
        end
      end
      default: state_nxt = ST_START;
    endcase
    if (wr_en) state_nxt = ST_START;
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg.log_mode  = log_mode_r;
  assign cfg.rows      = rows_c;
  assign cfg.cols      = cols_c;
  assign cfg.half_rows = rows_c[DIM_W-1:1];
  assign cfg.half_cols = cols_c[DIM_W-1:1];
  assign cfg.lg        = l_r;
  assign cfg.sq        = sq_r;
  assign cfg.root      = root_r;
endmodule
`default_nettype wire

### rtl/prc_front.sv
// Front pipeline: takes pixel requests, divides for angle and radius, builds the
// log-polar radius by a chain of root-of-two products. Uses prc_pkg and prc_in_if.
`default_nettype none
module prc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prc_pkg::prc_cfg_t    cfg,
  input  logic                 busy,
  prc_in_if.sink               in_chan,
  input  logic                 q_full,
  output logic                 push,
  output prc_pkg::prc_item_t   push_item
);
  import prc_pkg::*;

  localparam int MUL_N = ROOT_N;
  localparam int HI_W  = NUM_W - 16;

  logic                  ce;
  logic [NUM_W:0]        dv_r;
  logic [DIM_W-1:0]      rema_r [0:NUM_W];
  logic [NUM_W-1:0]      nqa_r  [0:NUM_W];
  logic [DIM_W-1:0]      remr_r [0:NUM_W];
  logic [NUM_W-1:0]      nqr_r  [0:NUM_W];
  logic [MUL_N:0]        mv_r;
  logic [ROOT_W-1:0]     v_r    [0:MUL_N];
  logic [RHO_W-1:0]      rlin_r [0:MUL_N];
  logic [ANG_W-1:0]      ang_r  [0:MUL_N];
  logic [15:0]           f_r    [0:MUL_N];
  logic [3:0]            n_r    [0:MUL_N];
  logic                  cap_r  [0:MUL_N];
  logic                  fv_r;
  prc_item_t             item_r;
  logic [NUM_W-1:0]      rho_num, qa, qr;
  logic [ROOT_W+13:0]    shl;
  logic [RHO_W-1:0]      rho_log;

  function automatic logic [DIM_W+NUM_W-1:0] div_step(
    input logic [DIM_W-1:0] rem,
    input logic [NUM_W-1:0] nq,
    input logic [DIM_W-1:0] d
  );
    logic [DIM_W:0] t;
    logic           q;
    t = {rem, nq[NUM_W-1]};
    q = (t >= {1'b0, d});
    if (q) t = t - {1'b0, d};
    return {t[DIM_W-1:0], nq[NUM_W-2:0], q};
  endfunction

  assign ce            = !(fv_r && q_full);
  assign push          = fv_r && !q_full;
  assign push_item     = item_r;
  assign in_chan.ready = ce && !busy;

  always_comb begin
    if (cfg.log_mode) begin
      rho_num = NUM_W'(in_chan.col_index) * NUM_W'(cfg.lg);
    end else begin
      rho_num = NUM_W'(in_chan.col_index) * NUM_W'(cfg.sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      mv_r <= '0;
      fv_r <= 1'b0;
    end else if (ce) begin
      dv_r <= {dv_r[NUM_W-1:0], in_chan.valid && in_chan.ready};
      mv_r <= {mv_r[MUL_N-1:0], dv_r[NUM_W]};
      fv_r <= mv_r[MUL_N];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rema_r[0] <= '0;
      nqa_r[0]  <= {in_chan.row_index, {(NUM_W-COORD_W-HALF_W){1'b0}}, cfg.half_rows};
      remr_r[0] <= '0;
      nqr_r[0]  <= rho_num;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (ce) begin
        {rema_r[k+1], nqa_r[k+1]} <= div_step(rema_r[k], nqa_r[k], cfg.rows);
        {remr_r[k+1], nqr_r[k+1]} <= div_step(remr_r[k], nqr_r[k], cfg.cols);
      end
    end
  end

  assign qa = nqa_r[NUM_W];
  assign qr = nqr_r[NUM_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      v_r[0]    <= ONE_Q30;
      rlin_r[0] <= (qr > NUM_W'(RHO_CAP)) ? RHO_CAP : qr[RHO_W-1:0];
      ang_r[0]  <= qa[ANG_W-1:0];
      f_r[0]    <= qr[15:0];
      n_r[0]    <= qr[19:16];
      cap_r[0]  <= (qr[NUM_W-1:16] >= HI_W'(15));
    end
  end

  for (genvar j = 0; j < MUL_N; j++) begin : g_mul
    logic [2*ROOT_W-1:0] prod;
    assign prod = (2*ROOT_W)'(v_r[j]) * (2*ROOT_W)'(cfg.root[j]);
    always_ff @(posedge clk) begin
      if (ce) begin
        v_r[j+1]    <= f_r[j][15-j] ? prod[2*ROOT_W-2:ROOT_W-1] : v_r[j];
        rlin_r[j+1] <= rlin_r[j];
        ang_r[j+1]  <= ang_r[j];
        f_r[j+1]    <= f_r[j];
        n_r[j+1]    <= n_r[j];
        cap_r[j+1]  <= cap_r[j];
      end
    end
  end

  assign shl     = {14'd0, v_r[MUL_N]} << n_r[MUL_N];
  assign rho_log = {1'b0, shl[ROOT_W+13:14]} - 32'd65536;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (cfg.log_mode) begin
        item_r.rho <= cap_r[MUL_N] ? RHO_CAP : rho_log;
        item_r.ang <= 32'd0 - ang_r[MUL_N];
      end else begin
        item_r.rho <= rlin_r[MUL_N];
        item_r.ang <= ang_r[MUL_N] + 32'h8000_0000;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/prc_queue.sv
// Short request queue between the front and back pipelines.
// Uses prc_pkg.
`default_nettype none
module prc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  prc_pkg::prc_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output prc_pkg::prc_item_t  pop_item
);
  import prc_pkg::*;

  prc_item_t       mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end
endmodule
`default_nettype wire

### rtl/prc_back.sv
// Back pipeline: gain-compensated CORDIC rotation, center offset, rounding and
// saturation into the result register. Uses prc_pkg and prc_out_if.
`default_nettype none
module prc_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prc_pkg::prc_cfg_t   cfg,
  input  logic                q_empty,
  input  prc_pkg::prc_item_t  q_item,
  output logic                pop,
  prc_out_if.source           out_chan
);
  import prc_pkg::*;

  localparam int SH    = 16 - FRAC_BITS;
  localparam int SUM_W = CX_W + 2;
  localparam logic signed [SUM_W-1:0] RND  = SUM_W'((1 << SH) >> 1);
  localparam logic signed [Z_W-1:0]   QTR  = Z_W'(64'sd1073741824);
  localparam logic signed [Z_W-1:0]   HALF = Z_W'(64'sd2147483648);

  logic                     ce;
  logic [2*RHO_W-3:0]       gp;
  logic                     b0v_r;
  logic signed [CX_W-1:0]   cx0_r;
  logic signed [Z_W-1:0]    z0_r;
  logic [CORDIC_N:0]        cv_r;
  logic signed [CX_W-1:0]   cx_r [0:CORDIC_N];
  logic signed [CX_W-1:0]   cy_r [0:CORDIC_N];
  logic signed [Z_W-1:0]    z_r  [0:CORDIC_N];
  logic signed [SUM_W-1:0]  sx, sy, rx, ry;
  logic                     out_vld_r;
  logic signed [OUT_W-1:0]  sx_r, sy_r;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(2**(OUT_W-1)-1)) return {1'b0, {(OUT_W-1){1'b1}}};
    if (v < SUM_W'(-(2**(OUT_W-1)))) return {1'b1, {(OUT_W-1){1'b0}}};
    return v[OUT_W-1:0];
  endfunction

  assign ce  = !out_vld_r || out_chan.ready;
  assign pop = ce && !q_empty;
  assign gp  = (2*RHO_W-2)'(q_item.rho) * (2*RHO_W-2)'(CORDIC_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0v_r     <= 1'b0;
      cv_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (ce) begin
      b0v_r     <= pop;
      cv_r      <= {cv_r[CORDIC_N-1:0], b0v_r};
      out_vld_r <= cv_r[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cx0_r <= signed'({2'b00, gp[2*RHO_W-3:30]});
      z0_r  <= signed'({q_item.ang[ANG_W-1], q_item.ang});
      cy_r[0] <= '0;
      if (z0_r > QTR) begin
        z_r[0]  <= z0_r - HALF;
        cx_r[0] <= -cx0_r;
      end else if (z0_r < -QTR) begin
        z_r[0]  <= z0_r + HALF;
        cx_r[0] <= -cx0_r;
      end else begin
        z_r[0]  <= z0_r;
        cx_r[0] <= cx0_r;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
    logic signed [CX_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;
    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign at = signed'({{(Z_W-ATAN_W){1'b0}}, atan_turn(i)});
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!z_r[i][Z_W-1]) begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          z_r[i+1]  <= z_r[i] - at;
        end else begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          z_r[i+1]  <= z_r[i] + at;
        end
      end
    end
  end

  assign sx = SUM_W'(cx_r[CORDIC_N])
            + signed'({{(SUM_W-HALF_W-16){1'b0}}, cfg.half_cols, 16'd0});
  assign sy = SUM_W'(cy_r[CORDIC_N])
            + signed'({{(SUM_W-HALF_W-16){1'b0}}, cfg.half_rows, 16'd0});
  assign rx = (sx + RND) >>> SH;
  assign ry = (sy + RND) >>> SH;

  always_ff @(posedge clk) begin
    if (ce) begin
      sx_r <= sat(rx);
      sy_r <= sat(ry);
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.source_x = sx_r;
  assign out_chan.source_y = sy_r;
endmodule
`default_nettype wire

### rtl/polar_remap_coordinate_generator.sv
// Top level of the polar / log-polar remap coordinate generator.
// Depends on prc_pkg, prc_if, prc_cfg, prc_front, prc_queue and prc_back.
//
// For each output pixel request (col_index, row_index) the block returns the
// signed Q13.8 source coordinates for a polar or log-polar unwrap about the image
// center. One request is taken per clock unless setup runs or a full queue stalls
// the front; each passes the two 44-step pipelined dividers, the 16-stage
// root-of-two product chain and the 20-stage CORDIC. After reset and after every
// register write a setup sequencer runs (16 squaring steps for log2 of the row count,
// then 17 square roots on one bit-per-cycle unit); in_chan.ready stays low meanwhile.
// Front and back are joined by a 4-entry queue, so the output side may stall
// without stopping the front until the queue fills.
`default_nettype none
module polar_remap_coordinate_generator #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  prc_in_if.sink                      in_chan,
  prc_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]  paddr,
  input  logic [prc_pkg::DATA_W-1:0]  pwdata,
  output logic [prc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import prc_pkg::*;

  prc_cfg_t  cfg;
  logic      busy;
  logic      push, q_full, pop, q_empty;
  prc_item_t push_item, pop_item;

  assign pready = 1'b1;

  prc_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .busy    (busy)
  );

  prc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .busy      (busy),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  prc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  prc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (pop_item),
    .pop      (pop),
    .out_chan (out_chan)
  );
endmodule
`default_nettype wire

### bench/prc_result_checker.sv
// Checker for the polar remap coordinate generator: predicts source coordinates
// for every accepted request and compares them with the results in order.
// Depends on prc_pkg and prc_if.
module prc_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  prc_in_if                           in_mon,
  prc_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]  paddr,
  input  logic [prc_pkg::DATA_W-1:0]  pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);
  import prc_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
  } coord_t;

  localparam longint ARC_TURNS [CORDIC_N] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };
  localparam longint SAT_HI = 2097151;
  localparam longint SAT_LO = -2097152;

  logic             mode_log;
  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] cols_reg;
  coord_t           coord_q[$];
  int               mism;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dim_eff(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > 4096) return 4096;
    return d;
  endfunction

  function automatic longint unsigned log_rho(longint unsigned x, longint unsigned rows,
                                              longint unsigned cols);
    int unsigned     msb;
    longint unsigned m, l, e, n, f, v, c;
    msb = 0;
    while (msb < 13 && (rows >> (msb + 1)) != 0) msb++;
    m = rows << (30 - msb);
    l = msb;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      l <<= 1;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        l |= 1;
      end
    end
    e = (x * l) / cols;
    n = e >> 16;
    f = e & 64'hFFFF;
    if (n >= 15) return 64'h8000_0000;
    v = 64'd1 << 30;
    c = 64'd2 << 30;
    for (int i = 1; i <= 16; i++) begin
      c = int_sqrt(c << 30);
      if ((f >> (16 - i)) & 1) v = (v * c) >> 30;
    end
    return ((v << n) >> 14) - 65536;
  endfunction

  function automatic longint round_sat(longint v);
    v = (v + 128) >>> 8;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v;
  endfunction

  function automatic coord_t source_coord(longint unsigned x, longint unsigned y);
    longint unsigned rows, cols, hr, hc, rho, p;
    longint          z, cx, cy, t, dx, dy;
    coord_t          r;
    rows = dim_eff(rows_reg);
    cols = dim_eff(cols_reg);
    hr = rows / 2;
    hc = cols / 2;
    p = (((y << 32) + rows / 2) / rows) & 64'hFFFF_FFFF;
    if (mode_log) begin
      p = (64'h1_0000_0000 - p) & 64'hFFFF_FFFF;
      rho = log_rho(x, rows, cols);
    end else begin
      p = (p + 64'h8000_0000) & 64'hFFFF_FFFF;
      rho = (int_sqrt((hr * hr + hc * hc) << 32) * x) / cols;
    end
    if (rho > 64'h8000_0000) rho = 64'h8000_0000;
    cx = longint'((rho * 64'd652032874) >> 30);
    cy = 0;
    z = (p >= 64'h8000_0000) ? longint'(p) - 64'sd4294967296 : longint'(p);
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      cx = -cx;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      cx = -cx;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        t = cx - dx;
        cy = cy + dy;
        z -= ARC_TURNS[i];
      end else begin
        t = cx + dx;
        cy = cy - dy;
        z += ARC_TURNS[i];
      end
      cx = t;
    end
    r.sx = OUT_W'(round_sat(cx + longint'(hc << 16)));
    r.sy = OUT_W'(round_sat(cy + longint'(hr << 16)));
    return r;
  endfunction

  always @(posedge clk) begin
    coord_t exp_c;
    if (!rst_n) begin
      mode_log <= 1'b0;
      rows_reg <= 13'd512;
      cols_reg <= 13'd512;
      fail_count <= 0;
      pending <= 0;
      mism = 0;
      coord_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LOG_MODE:   mode_log <= pwdata[0];
          REG_IMAGE_ROWS: rows_reg <= pwdata[DIM_W-1:0];
          REG_IMAGE_COLS: cols_reg <= pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (coord_q.size() == 0) begin
          fail_count <= fail_count + 1;
          mism++;
          if (mism <= 10)
            $display("unexpected result x=%0d y=%0d", out_mon.source_x, out_mon.source_y);
        end else begin
          exp_c = coord_q.pop_front();
          if (exp_c.sx !== out_mon.source_x || exp_c.sy !== out_mon.source_y) begin
            fail_count <= fail_count + 1;
            mism++;
            if (mism <= 10)
              $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       exp_c.sx, exp_c.sy, out_mon.source_x, out_mon.source_y);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        coord_q.push_back(source_coord(in_mon.col_index, in_mon.row_index));
      pending <= coord_q.size();
    end
  end
endmodule

### bench/tb_polar_remap_coordinate_generator.sv
// Testbench top: drives pixel requests and register writes into the remap coordinate generator
// and gives the verdict. Depends on prc_pkg, prc_if, the generator top and prc_result_checker.
module tb_polar_remap_coordinate_generator;
  import prc_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  int   fail_count, pending, cycles;
  logic no_idle, long_hold;

  prc_in_if  in_bus();
  prc_out_if out_bus();

  polar_remap_coordinate_generator u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_bus), .out_chan(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  prc_result_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_polar_remap_coordinate_generator failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_bus.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int n;
    in_bus.valid <= 1'b1;
    in_bus.col_index <= x;
    in_bus.row_index <= y;
    do @(posedge clk); while (!in_bus.ready);
    n = gap_len();
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(input logic lm, input logic [12:0] r, input logic [12:0] c);
    drain();
    reg_write(REG_LOG_MODE, {31'd0, lm});
    reg_write(REG_IMAGE_ROWS, {19'd0, r});
    reg_write(REG_IMAGE_COLS, {19'd0, c});
  endtask

  task automatic rand_reqs(input int cnt, input int span);
    repeat (cnt) begin
      if ($urandom_range(0, 3) == 0)
        send_req(COORD_W'($urandom), COORD_W'($urandom));
      else
        send_req(COORD_W'($urandom_range(0, span)), COORD_W'($urandom_range(0, span)));
    end
  endtask

  initial begin
    logic [12:0] r, c;
    rst_n = 1'b0;
    cycles = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.col_index = '0;
    in_bus.row_index = '0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_req(12'd0, 12'd0);
    send_req(12'd4095, 12'd4095);
    send_req(12'd511, 12'd128);
    send_req(12'd256, 12'd384);
    send_req(12'd4095, 12'd0);
    send_req(12'd0, 12'd4095);
    drain();
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    set_cfg(1'b1, 13'd4096, 13'd1);
    send_req(12'd0, 12'd1);
    send_req(12'd14, 12'd2048);
    send_req(12'd4095, 12'd4095);
    set_cfg(1'b1, 13'd0, 13'd0);
    send_req(12'd0, 12'd0);
    send_req(12'd1, 12'd3);
    set_cfg(1'b0, 13'd8191, 13'd4096);
    send_req(12'd4095, 12'd1024);
    send_req(12'd2048, 12'd3072);
    set_cfg(1'b0, 13'd1, 13'd8191);
    send_req(12'd4095, 12'd7);
    send_req(12'd100, 12'd0);
    set_cfg(1'b1, 13'd640, 13'd480);
    send_req(12'd479, 12'd320);
    send_req(12'd240, 12'd639);

    set_cfg(1'b0, 13'd512, 13'd512);
    do @(posedge clk); while (!in_bus.ready);
    long_hold = 1'b1;
    no_idle = 1'b1;
    rand_reqs(200, 511);
    no_idle = 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      r = 13'($urandom_range(1, 4096));
      c = 13'($urandom_range(1, 4096));
      if (ph == 2) r = 13'd4096;
      if (ph == 3) c = 13'd1;
      set_cfg(1'($urandom), r, c);
      rand_reqs(40, (r > c ? r : c) - 1);
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("tb_polar_remap_coordinate_generator passed");
    else
      $display("tb_polar_remap_coordinate_generator failed");
    $finish;
  end
endmodule

### filelist.f
rtl/prc_pkg.sv
rtl/prc_if.sv
rtl/prc_cfg.sv
rtl/prc_front.sv
rtl/prc_queue.sv
rtl/prc_back.sv
rtl/polar_remap_coordinate_generator.sv
bench/prc_result_checker.sv
bench/tb_polar_remap_coordinate_generator.sv
